// File: sv/shp_pkg.sv
// Shared types, constants and the sharpening arithmetic for the 3x3 sharpen core.
// Used by shp_result_queue and sharpen_3x3_filter_core; depends on nothing else.
package shp_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CHAN_W      = 8;
    localparam int NUM_SLOTS   = 4;
    localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * CHAN_W - COL_W - ROW_W;

    // Slot order of one pixel's results
    localparam int SLOT_PREV_ROW_PREV_COL = 0;
    localparam int SLOT_PREV_ROW_LAST_COL = 1;
    localparam int SLOT_CUR_ROW_PREV_COL  = 2;
    localparam int SLOT_CUR_ROW_LAST_COL  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        pixel_t older;
        pixel_t newer;
    } line_pair_t;

    typedef struct packed {
        pixel_t           px;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             frame_last;
    } result_t;

    typedef struct packed {
        logic                 valid;
        logic [NUM_SLOTS-1:0] mask;
    } queue_load_t;

    // Clamp a dimension register to 2..maxv and return its last index
    function automatic logic [CFG_W-1:0] last_index(input logic [CFG_W-1:0] dim,
                                                     input logic [CFG_W-1:0] maxv);
        logic [CFG_W-1:0] d;
        if (dim < CFG_W'(2)) begin
            d = CFG_W'(2);
        end else if (dim > maxv) begin
            d = maxv;
        end else begin
            d = dim;
        end
        return d - CFG_W'(1);
    endfunction

    function automatic logic [CHAN_W-1:0] sharpen_chan(input logic [CHAN_W-1:0] center,
                                                       input logic [CHAN_W-1:0] nbr [8]);
        logic [11:0]        sum;
        logic [11:0]        nine;
        logic signed [12:0] acc;
        sum = '0;
        for (int k = 0; k < 8; k++) begin
            sum = sum + 12'(nbr[k]);
        end
        nine = 12'({center, 3'b000}) + 12'(center);
        acc  = $signed({1'b0, nine}) - $signed({1'b0, sum});
        if (acc < 0) begin
            return '0;
        end else if (acc > 13'sd255) begin
            return '1;
        end else begin
            return acc[CHAN_W-1:0];
        end
    endfunction

    function automatic pixel_t sharpen_px(input pixel_t center, input pixel_t nbr [8]);
        logic [CHAN_W-1:0] r_n [8];
        logic [CHAN_W-1:0] g_n [8];
        logic [CHAN_W-1:0] b_n [8];
        pixel_t            res;
        for (int k = 0; k < 8; k++) begin
            r_n[k] = nbr[k].red;
            g_n[k] = nbr[k].green;
            b_n[k] = nbr[k].blue;
        end
        res.red   = sharpen_chan(center.red, r_n);
        res.green = sharpen_chan(center.green, g_n);
        res.blue  = sharpen_chan(center.blue, b_n);
        return res;
    endfunction

endpackage

// File: sv/shp_result_queue.sv
// Result slot set: holds the up to four results released by one pixel and
// sends them out one beat at a time. Depends on shp_pkg.
module shp_result_queue (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  shp_pkg::queue_load_t            load,
    input  shp_pkg::result_t                load_slots [shp_pkg::NUM_SLOTS],
    output logic                            load_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, low bit up: out_red, out_green, out_blue, pixel_column, pixel_row, zero pad
    output logic [shp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    // m_tuser: frame_last
    output logic                            m_tuser
);
    import shp_pkg::*;

    logic [NUM_SLOTS-1:0]  mask_reg;
    logic [NUM_SLOTS-1:0]  mask_next;
    result_t               slot_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  pick;
    logic [NUM_SLOTS-1:0]  rest;
    logic [SLOT_IDX_W-1:0] sel;
    result_t               cur;

    // Lowest pending slot goes first
    always_comb begin
        sel = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
            if (mask_reg[k]) begin
                sel = SLOT_IDX_W'(k);
            end
        end
    end

    assign pick       = mask_reg & (~mask_reg + NUM_SLOTS'(1));
    assign rest       = mask_reg & ~pick;
    assign cur        = slot_reg[sel];
    assign m_tvalid   = |mask_reg;
    assign m_tlast    = (rest == '0);
    assign m_tuser    = cur.frame_last;
    assign m_tdata    = {OUT_PAD_W'(0), cur.row, cur.col, cur.px.blue, cur.px.green, cur.px.red};
    assign load_ready = (mask_reg == '0) || ((rest == '0) && m_tready);

    always_comb begin
        mask_next = mask_reg;
        if (load.valid) begin
            mask_next = load.mask;
        end else if (m_tvalid && m_tready) begin
            mask_next = rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                slot_reg[k] <= load_slots[k];
            end
        end
    end

endmodule

// File: sv/sharpen_3x3_filter_core.sv
// Top level of the 3x3 sharpen core: line store memory, pixel window and
// result release. Depends on shp_pkg and shp_result_queue.
//
//  channel | direction | ports                            | beat
//  --------+-----------+----------------------------------+-----------------------------
//  s_      | in        | s_tvalid s_tready s_tdata        | one raster-order RGB pixel
//  m_      | out       | m_tvalid m_tready m_tdata/tlast/ | one emitted pixel with its
//          |           | tuser                            | position, run and frame marks
//  cfg_    | in        | cfg_valid cfg_ready cfg_index    | one register write
//          |           | cfg_data                         |
//
// One pixel is accepted per cycle while each pixel releases at most one result and m_ does
// not stall; every extra result of a pixel (last column, last row) holds the input back
// while it leaves by the single output port. The pixel and its line memory read register
// in the window stage, the window arithmetic result in the result slots. Reset clears
// counters, control and the window; the line memory holds no reset value and needs no
// clearing pass. A stall on m_ backs up through result slots and window stage to s_tready.
module sharpen_3x3_filter_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, low bit up: red, green, blue
    input  logic [shp_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, low bit up: out_red, out_green, out_blue, pixel_column, pixel_row, zero pad
    output logic [shp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast,
    // m_tuser: frame_last
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [shp_pkg::CFG_W-1:0]       cfg_data
);
    import shp_pkg::*;

    // Configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W-1:0] last_col_idx;
    logic [ROW_W-1:0] last_row_idx;

    // Input position
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic             in_last_col;
    logic             in_last_row;
    logic             accept;

    // Window stage
    logic             b_valid_reg;
    logic             b_valid_next;
    pixel_t           b_pixel_reg;
    logic [COL_W-1:0] b_col_reg;
    logic [ROW_W-1:0] b_row_reg;
    logic             b_last_col_reg;
    logic             b_last_row_reg;
    logic             b_adv;

    // Line memory
    line_pair_t       line_mem [MAX_WIDTH];
    line_pair_t       line_rd_reg;

    pixel_t           win_reg [6];

    // Release
    queue_load_t          load;
    logic [NUM_SLOTS-1:0] rel_mask;
    result_t              slots [NUM_SLOTS];
    logic                 q_ready;
    pixel_t               nbr [8];
    pixel_t               top_px;
    pixel_t               mid_px;
    pixel_t               first_px;
    logic                 col_ge1;
    logic                 row_ge1;
    logic                 interior;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(MAX_WIDTH);
            height_reg <= CFG_W'(MAX_HEIGHT);
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign last_col_idx = COL_W'(last_index(width_reg, CFG_W'(MAX_WIDTH)));
    assign last_row_idx = ROW_W'(last_index(height_reg, CFG_W'(MAX_HEIGHT)));

    assign in_last_col = (col_reg >= last_col_idx);
    assign in_last_row = (row_reg >= last_row_idx);
    assign accept      = s_tvalid && s_tready;
    assign s_tready    = !b_valid_reg || b_adv;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (in_last_col) begin
                col_next = '0;
                row_next = in_last_row ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (accept) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pixel_reg    <= pixel_t'({s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]});
            b_col_reg      <= col_reg;
            b_row_reg      <= row_reg;
            b_last_col_reg <= in_last_col;
            b_last_row_reg <= in_last_row;
        end
    end

    // Read on accept, write back on release. Neighboring pixels never share a
    // column, so the pending write never hits the address being read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_rd_reg <= line_mem[col_reg];
        end
        if (b_adv) begin
            line_mem[b_col_reg] <= '{older: line_rd_reg.newer, newer: b_pixel_reg};
        end
    end

    assign top_px   = line_rd_reg.older;
    assign mid_px   = line_rd_reg.newer;
    assign col_ge1  = (b_col_reg != '0);
    assign row_ge1  = (b_row_reg != '0);
    assign interior = (b_col_reg >= COL_W'(2)) && (b_row_reg >= ROW_W'(2));

    assign nbr[0] = win_reg[3];
    assign nbr[1] = win_reg[0];
    assign nbr[2] = top_px;
    assign nbr[3] = win_reg[4];
    assign nbr[4] = mid_px;
    assign nbr[5] = win_reg[5];
    assign nbr[6] = win_reg[2];
    assign nbr[7] = b_pixel_reg;

    assign first_px = interior ? sharpen_px(win_reg[1], nbr) : win_reg[1];

    always_comb begin
        slots[SLOT_PREV_ROW_PREV_COL] = '{px: first_px, col: b_col_reg - COL_W'(1),
                                          row: b_row_reg - ROW_W'(1), frame_last: 1'b0};
        slots[SLOT_PREV_ROW_LAST_COL] = '{px: mid_px, col: b_col_reg,
                                          row: b_row_reg - ROW_W'(1), frame_last: 1'b0};
        slots[SLOT_CUR_ROW_PREV_COL]  = '{px: win_reg[2], col: b_col_reg - COL_W'(1),
                                          row: b_row_reg, frame_last: 1'b0};
        slots[SLOT_CUR_ROW_LAST_COL]  = '{px: b_pixel_reg, col: b_col_reg,
                                          row: b_row_reg, frame_last: 1'b1};
    end

    always_comb begin
        rel_mask = '0;
        rel_mask[SLOT_PREV_ROW_PREV_COL] = row_ge1 && col_ge1;
        rel_mask[SLOT_PREV_ROW_LAST_COL] = row_ge1 && b_last_col_reg;
        rel_mask[SLOT_CUR_ROW_PREV_COL]  = b_last_row_reg && col_ge1;
        rel_mask[SLOT_CUR_ROW_LAST_COL]  = b_last_row_reg && b_last_col_reg;
    end

    // A pixel that releases nothing still advances the window and memory
    assign b_adv = b_valid_reg && ((rel_mask == '0) || q_ready);
    assign load  = '{valid: b_adv && (rel_mask != '0), mask: rel_mask};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) begin
                win_reg[k] <= '0;
            end
        end else if (b_adv) begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top_px;
            win_reg[1] <= mid_px;
            win_reg[2] <= b_pixel_reg;
        end
    end

    shp_result_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .load_slots (slots),
        .load_ready (q_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule
